@@ sv/cufc_pkg.sv @@
package cufc_pkg;

    // fixed-point scaling of the percent results
    localparam int FRAC_BITS = 8;
    localparam int SCALE     = 100 << FRAC_BITS;
    localparam int SCALE_W   = $clog2(SCALE + 1);

    // datapath widths
    localparam int CNT_W   = 64;
    localparam int TIME_W  = 63;
    localparam int HALF_W  = 32;
    localparam int PROD_W  = HALF_W + SCALE_W;
    localparam int DVD_W   = CNT_W + SCALE_W;
    localparam int STEP_W  = $clog2(DVD_W);
    localparam int PPCT_W  = 24;
    localparam int SPCT_W  = 15;
    localparam int QUO_W   = PPCT_W + 1;
    localparam int STAT_W  = 3;

    // channel status codes
    localparam logic [STAT_W-1:0] STAT_NONE    = 3'd0;
    localparam logic [STAT_W-1:0] STAT_BASE    = 3'd1;
    localparam logic [STAT_W-1:0] STAT_RESET   = 3'd2;
    localparam logic [STAT_W-1:0] STAT_INVALID = 3'd3;
    localparam logic [STAT_W-1:0] STAT_VALID   = 3'd4;

    typedef struct packed {
        logic              process_present;
        logic [TIME_W-1:0] process_time_us;
        logic [TIME_W-1:0] wall_time_us;
        logic              system_present;
        logic [CNT_W-1:0]  busy_ticks;
        logic [CNT_W-1:0]  total_ticks;
    } cufc_in_t;

    typedef struct packed {
        logic [STAT_W-1:0] process_status;
        logic [PPCT_W-1:0] process_percent;
        logic [STAT_W-1:0] system_status;
        logic [SPCT_W-1:0] system_percent;
    } cufc_out_t;

    // classified sample handed from front to back
    typedef struct packed {
        logic [STAT_W-1:0] p_status;
        logic [CNT_W-1:0]  p_delta;
        logic [CNT_W-1:0]  p_divisor;
        logic [STAT_W-1:0] s_status;
        logic [CNT_W-1:0]  s_delta;
        logic [CNT_W-1:0]  s_divisor;
    } cufc_job_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_MUL,
        BK_SUM,
        BK_DIV,
        BK_DONE
    } back_state_t;

    typedef struct packed {
        logic pop;
        logic mul;
        logic sum;
        logic div;
        logic out_load;
    } back_ctrl_t;

endpackage

@@ sv/cufc_front.sv @@
module cufc_front import cufc_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  cufc_in_t  s_data,
    output logic      push_valid,
    input  logic      push_ready,
    output cufc_job_t push_data
);

    logic              have_p_reg, have_p_next;
    logic [TIME_W-1:0] last_p_reg, last_p_next;
    logic [TIME_W-1:0] last_wall_reg, last_wall_next;
    logic              have_s_reg, have_s_next;
    logic [CNT_W-1:0]  last_busy_reg, last_busy_next;
    logic [CNT_W-1:0]  last_total_reg, last_total_next;
    logic              accept;
    logic [CNT_W-1:0]  dbusy;
    logic [CNT_W-1:0]  dtotal;

    assign s_ready    = push_ready;
    assign push_valid = s_valid;
    assign accept     = s_valid && push_ready;

    assign dbusy  = s_data.busy_ticks - last_busy_reg;
    assign dtotal = s_data.total_ticks - last_total_reg;

    // classify the word against the stored snapshots
    always_comb begin
        push_data.p_delta   = {1'b0, s_data.process_time_us - last_p_reg};
        push_data.p_divisor = {1'b0, s_data.wall_time_us - last_wall_reg};
        push_data.s_delta   = dbusy;
        push_data.s_divisor = dtotal;

        if (!s_data.process_present) begin
            push_data.p_status = STAT_NONE;
        end else if (!have_p_reg) begin
            push_data.p_status = STAT_BASE;
        end else if (s_data.process_time_us < last_p_reg) begin
            push_data.p_status = STAT_RESET;
        end else if (s_data.wall_time_us <= last_wall_reg) begin
            push_data.p_status = STAT_INVALID;
        end else begin
            push_data.p_status = STAT_VALID;
        end

        if (!s_data.system_present) begin
            push_data.s_status = STAT_NONE;
        end else if (!have_s_reg) begin
            push_data.s_status = STAT_BASE;
        end else if (s_data.busy_ticks < last_busy_reg ||
                     s_data.total_ticks < last_total_reg) begin
            push_data.s_status = STAT_RESET;
        end else if (dtotal == '0 || dbusy > dtotal) begin
            push_data.s_status = STAT_INVALID;
        end else begin
            push_data.s_status = STAT_VALID;
        end
    end

    // snapshot update
    always_comb begin
        have_p_next     = have_p_reg;
        last_p_next     = last_p_reg;
        last_wall_next  = last_wall_reg;
        have_s_next     = have_s_reg;
        last_busy_next  = last_busy_reg;
        last_total_next = last_total_reg;
        if (accept && s_data.process_present) begin
            have_p_next    = 1'b1;
            last_p_next    = s_data.process_time_us;
            last_wall_next = s_data.wall_time_us;
        end
        if (accept && s_data.system_present) begin
            have_s_next     = 1'b1;
            last_busy_next  = s_data.busy_ticks;
            last_total_next = s_data.total_ticks;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            have_p_reg     <= 1'b0;
            last_p_reg     <= '0;
            last_wall_reg  <= '0;
            have_s_reg     <= 1'b0;
            last_busy_reg  <= '0;
            last_total_reg <= '0;
        end else begin
            have_p_reg     <= have_p_next;
            last_p_reg     <= last_p_next;
            last_wall_reg  <= last_wall_next;
            have_s_reg     <= have_s_next;
            last_busy_reg  <= last_busy_next;
            last_total_reg <= last_total_next;
        end
    end

endmodule

@@ sv/cufc_queue.sv @@
module cufc_queue import cufc_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      push_valid,
    output logic      push_ready,
    input  cufc_job_t push_data,
    output logic      pop_valid,
    input  logic      pop_ready,
    output cufc_job_t pop_data
);

    cufc_job_t  mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_push;
    logic       do_pop;

    assign push_ready = count_reg != 2'd2;
    assign pop_valid  = count_reg != 2'd0;
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // pointer and fill tracking
    always_comb begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 2'd1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

@@ sv/cufc_back.sv @@
module cufc_back import cufc_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      pop_valid,
    output logic      pop_ready,
    input  cufc_job_t pop_data,
    output logic      m_valid,
    input  logic      m_ready,
    output cufc_out_t m_data
);

    back_state_t       state_reg, state_next;
    back_ctrl_t        ctrl;
    cufc_job_t         job_reg;
    logic              phase_reg;
    logic [PROD_W-1:0] prod_lo_reg;
    logic [PROD_W-1:0] prod_hi_reg;
    logic [DVD_W-1:0]  dvd_reg;
    logic [CNT_W-1:0]  rem_reg, rem_next;
    logic [QUO_W-1:0]  quo_reg, quo_next;
    logic [STEP_W-1:0] step_reg;
    logic [PPCT_W-1:0] ppct_reg;
    logic [SPCT_W-1:0] spct_reg;
    logic              m_valid_reg;
    cufc_out_t         m_data_reg;
    logic [CNT_W-1:0]  operand;
    logic [CNT_W-1:0]  divisor;
    logic [CNT_W:0]    rem_shift;
    logic              ge;
    logic [QUO_W:0]    quo_shift;
    logic              div_last;
    logic              out_free;

    assign operand   = phase_reg ? job_reg.s_delta : job_reg.p_delta;
    assign divisor   = phase_reg ? job_reg.s_divisor : job_reg.p_divisor;
    assign div_last  = step_reg == STEP_W'(DVD_W - 1);
    assign out_free  = !m_valid_reg || m_ready;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;
    assign pop_ready = ctrl.pop;

    // one restoring division step, quotient held saturated above the process limit
    always_comb begin
        rem_shift = {rem_reg, dvd_reg[DVD_W-1]};
        ge        = rem_shift >= {1'b0, divisor};
        rem_next  = ge ? CNT_W'(rem_shift - {1'b0, divisor}) : rem_shift[CNT_W-1:0];
        quo_shift = {quo_reg, ge};
        if (quo_shift[QUO_W:PPCT_W] != '0) begin
            quo_next = {1'b1, {PPCT_W{1'b0}}};
        end else begin
            quo_next = quo_shift[QUO_W-1:0];
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE: begin
                if (pop_valid) begin
                    if (pop_data.p_status == STAT_VALID || pop_data.s_status == STAT_VALID) begin
                        state_next = BK_MUL;
                    end else begin
                        state_next = BK_DONE;
                    end
                end
            end
            BK_MUL: begin
                state_next = BK_SUM;
            end
            BK_SUM: begin
                state_next = BK_DIV;
            end
            BK_DIV: begin
                if (div_last) begin
                    if (!phase_reg && job_reg.s_status == STAT_VALID) begin
                        state_next = BK_MUL;
                    end else begin
                        state_next = BK_DONE;
                    end
                end
            end
            BK_DONE: begin
                if (out_free) begin
                    state_next = BK_IDLE;
                end
            end
            default: begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // control decode
    always_comb begin
        ctrl = '0;
        case (state_reg)
            BK_IDLE: ctrl.pop      = 1'b1;
            BK_MUL:  ctrl.mul      = 1'b1;
            BK_SUM:  ctrl.sum      = 1'b1;
            BK_DIV:  ctrl.div      = 1'b1;
            BK_DONE: ctrl.out_load = out_free;
            default: ctrl = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= BK_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (ctrl.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // shared scale and divide datapath
    always_ff @(posedge aclk) begin
        if (ctrl.pop && pop_valid) begin
            job_reg   <= pop_data;
            phase_reg <= pop_data.p_status != STAT_VALID;
            ppct_reg  <= '0;
            spct_reg  <= '0;
        end
        if (ctrl.mul) begin
            prod_lo_reg <= PROD_W'(operand[HALF_W-1:0]) * PROD_W'(SCALE);
            prod_hi_reg <= PROD_W'(operand[CNT_W-1:HALF_W]) * PROD_W'(SCALE);
        end
        if (ctrl.sum) begin
            dvd_reg  <= DVD_W'(prod_lo_reg) + {prod_hi_reg, {HALF_W{1'b0}}};
            rem_reg  <= '0;
            quo_reg  <= '0;
            step_reg <= '0;
        end
        if (ctrl.div) begin
            dvd_reg  <= {dvd_reg[DVD_W-2:0], 1'b0};
            rem_reg  <= rem_next;
            quo_reg  <= quo_next;
            step_reg <= step_reg + STEP_W'(1);
            if (div_last) begin
                if (phase_reg) begin
                    spct_reg <= quo_next[SPCT_W-1:0];
                end else begin
                    ppct_reg  <= quo_next[PPCT_W] ? {PPCT_W{1'b1}} : quo_next[PPCT_W-1:0];
                    phase_reg <= 1'b1;
                end
            end
        end
        if (ctrl.out_load) begin
            m_data_reg.process_status  <= job_reg.p_status;
            m_data_reg.process_percent <= ppct_reg;
            m_data_reg.system_status   <= job_reg.s_status;
            m_data_reg.system_percent  <= spct_reg;
        end
    end

endmodule

@@ sv/cpu_utilization_from_counters.sv @@
// CPU utilization from cumulative counters. Each input word carries an optional
// process CPU time, optional system busy/total tick counters and a wall time; each
// word gives exactly one result word with a status and a percent (8 fraction bits,
// truncated) per channel. A front stage classifies the word against the stored
// snapshots combinationally and pushes it into a two-entry queue; the back stage
// runs one shared scale-and-divide unit: per channel that reports valid it steps
// through the scaling multiply (BK_MUL), the partial-product sum (BK_SUM) and a
// bit-serial restoring division (BK_DIV), then loads the result register in
// BK_DONE once it is free. The back-stage divider sets the sustained rate; the
// back stage works on one word at a time. The front keeps accepting up to two words
// ahead while the back stage is busy or a result waits on m_ready.
module cpu_utilization_from_counters import cufc_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  cufc_in_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output cufc_out_t m_data
);

    logic      push_valid;
    logic      push_ready;
    cufc_job_t push_data;
    logic      pop_valid;
    logic      pop_ready;
    cufc_job_t pop_data;

    // classification and snapshot state
    cufc_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    // decoupling queue
    cufc_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    // scale, divide and result register
    cufc_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    // percent fields are zero unless the channel reports valid
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.process_status != STAT_VALID |-> m_data.process_percent == '0)
        else $error("process percent set on a non-valid status");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.system_status != STAT_VALID |-> m_data.system_percent == '0)
        else $error("system percent set on a non-valid status");

    // system share never exceeds one hundred percent
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.system_percent <= SPCT_W'(SCALE))
        else $error("system percent above full scale");

endmodule
